// ===== hdl/ctf_pkg.sv =====
// shared widths, register codes and the arctangent table of the tilt filter
`timescale 1ns / 1ps
`default_nettype none
package ctf_pkg;
    localparam int IN_W    = 16;
    localparam int US_W    = 20;
    localparam int ANG_W   = 20;
    localparam int WT_W    = 17;
    localparam int GAIN_W  = 24;
    localparam int SQ_W    = 31;
    localparam int RAD_W   = 48;
    localparam int ROOT_W  = 24;
    localparam int REM_W   = 27;
    localparam int CV_W    = 28;
    localparam int Z_W     = 26;
    localparam int MC_W    = 40;
    localparam int PROD_W  = 60;
    localparam int DREM_W  = 29;
    localparam int QUO_W   = 32;
    localparam int DLT_W   = 34;
    localparam int BA_W    = 36;
    localparam int BN_W    = 56;
    localparam int RES_W   = 32;
    localparam int CNT_W   = 6;
    localparam int TAB_MAX = 24;
    localparam int TIDX_W  = 5;

    localparam logic [DREM_W-1:0] GYRO_DEN   = 29'd256000000;
    localparam logic [PROD_W-1:0] GYRO_HALF  = 60'd128000000;
    localparam logic [WT_W-1:0]   WT_ONE     = 17'd65536;
    localparam logic signed [Z_W-1:0]   Z_RIGHT  = 26'sd5898240;
    localparam logic signed [RES_W-1:0] ANG_MAXV = 32'sd524287;
    localparam logic signed [RES_W-1:0] ANG_MINV = -32'sd524288;
    localparam logic signed [BN_W-1:0]  RND_HALF = 56'sd8388608;

    localparam logic REG_BLEND = 1'b0;
    localparam logic REG_GAIN  = 1'b1;

    typedef logic signed [ANG_W-1:0] angle_t;
    typedef logic signed [CV_W-1:0]  cvec_t;
    typedef logic signed [Z_W-1:0]   zang_t;

    // atan(2^-i) in degrees, Q.16
    function automatic zang_t atan_entry(input logic [TIDX_W-1:0] i);
        zang_t v;
        case (i)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = 26'sd0;
        endcase
        return v;
    endfunction
endpackage
`default_nettype wire

// ===== hdl/complementary_tilt_filter.sv =====
// complementary tilt filter top level: sequencer, serial sqrt/cordic/multiply/divide units
`timescale 1ns / 1ps
`default_nettype none
// One six-axis sample beat in, one beat of three fused angles out. A single
// sequencer walks the three axes in turn: for roll and pitch a bit-pair serial
// square root for the accelerometer magnitude, then for every axis a
// one-iteration-per-cycle vectoring cordic for the tilt angle, a bit-serial
// multiply by elapsed_us and a bit-serial restoring divide by 256e6 for the
// gyro delta, then a bit-serial weighted blend. The gyro divide, run once per
// axis, is the longest step of an item. A new input beat is taken only while
// the sequencer is idle; a finished result sits in the output register until
// taken, so the next sample can already be in work.
// Registers: blend_weight at byte 0, gyro_gain at byte 4, readable.
module complementary_tilt_filter #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [2:0]                    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [ctf_pkg::IN_W-1:0]  accel_x,
    input  wire logic signed [ctf_pkg::IN_W-1:0]  accel_y,
    input  wire logic signed [ctf_pkg::IN_W-1:0]  accel_z,
    input  wire logic signed [ctf_pkg::IN_W-1:0]  gyro_x,
    input  wire logic signed [ctf_pkg::IN_W-1:0]  gyro_y,
    input  wire logic signed [ctf_pkg::IN_W-1:0]  gyro_z,
    input  wire logic [ctf_pkg::US_W-1:0]         elapsed_us,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [ctf_pkg::ANG_W-1:0]   roll_angle,
    output logic signed [ctf_pkg::ANG_W-1:0]   pitch_angle,
    output logic signed [ctf_pkg::ANG_W-1:0]   third_angle,
    output logic                               saturated
);
    import ctf_pkg::*;

    // table has TAB_MAX entries; more steps add nothing
    localparam int N_STEPS = (CORDIC_STEPS > TAB_MAX) ? TAB_MAX : CORDIC_STEPS;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SQ1   = 4'd1;
    localparam logic [3:0] ST_SQ2   = 4'd2;
    localparam logic [3:0] ST_SQRT  = 4'd3;
    localparam logic [3:0] ST_CINIT = 4'd4;
    localparam logic [3:0] ST_CORD  = 4'd5;
    localparam logic [3:0] ST_GM0   = 4'd6;
    localparam logic [3:0] ST_GMUL  = 4'd7;
    localparam logic [3:0] ST_GRND  = 4'd8;
    localparam logic [3:0] ST_GDIV  = 4'd9;
    localparam logic [3:0] ST_BINIT = 4'd10;
    localparam logic [3:0] ST_BLEND = 4'd11;
    localparam logic [3:0] ST_BFIN  = 4'd12;
    localparam logic [3:0] ST_DONE  = 4'd13;

    // configuration registers
    logic [WT_W-1:0]   blend_reg;
    logic [GAIN_W-1:0] gain_reg;

    logic [3:0]        state_reg;
    logic [1:0]        axis_reg;
    logic [CNT_W-1:0]  cnt_reg;

    // latched sample
    logic signed [IN_W-1:0] ax_reg, ay_reg, az_reg;
    logic signed [IN_W-1:0] g_reg [3];
    logic [US_W-1:0]        us_reg;

    // square root unit
    logic [SQ_W-1:0]   sq_reg;
    logic [RAD_W-1:0]  rad_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [REM_W-1:0]  rem_reg;

    // cordic unit
    cvec_t             cx_reg, cy_reg;
    zang_t             cz_reg;
    logic              zero_reg;
    zang_t             ang_reg [3];

    // gyro multiply / divide unit
    logic [PROD_W-1:0] mcand_reg;
    logic [US_W-1:0]   mplier_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [DREM_W-1:0] drem_reg;
    logic [QUO_W-1:0]  quo_reg;

    // blend unit
    logic signed [BN_W-1:0] ma_reg, mb_reg, acc_reg;
    logic [WT_W-1:0]        wa_reg, wb_reg;

    angle_t            fused_reg [3];
    logic              sat_reg;

    // output register
    logic              out_valid_reg;
    angle_t            roll_reg, pitch_reg, third_reg;
    logic              sat_out_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_comb
    begin
        unique case (paddr[2])
            REG_BLEND: prdata = {{(32-WT_W){1'b0}}, blend_reg};
            REG_GAIN:  prdata = {{(32-GAIN_W){1'b0}}, gain_reg};
            default:   prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            blend_reg <= 17'd64225;
            gain_reg  <= 24'd511500;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[2])
                REG_BLEND: blend_reg <= pwdata[WT_W-1:0];
                REG_GAIN:  gain_reg  <= pwdata[GAIN_W-1:0];
                default:   ;
            endcase
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

    logic in_acc;
    assign in_acc = in_valid && in_ready;

    // combinational step values
    logic signed [IN_W-1:0]   sq_a1, sq_a2;
    logic signed [2*IN_W-1:0] sq_p;
    logic [REM_W-1:0]         rem_sh, rem_trial;
    cvec_t                    ix, iy, xs, ys;
    logic [IN_W-1:0]          gmag;
    logic [DREM_W-1:0]        drem_sh;
    logic signed [DLT_W-1:0]  delta;
    logic signed [BA_W-1:0]   bsum;
    logic [WT_W-1:0]          wclamp;
    logic signed [BN_W-1:0]   nsum;
    logic signed [RES_W-1:0]  res;
    angle_t                   res_clamp;
    logic                     res_sat;

    always_comb
    begin
        sq_a1 = (axis_reg == 2'd0) ? ax_reg : ay_reg;
        sq_a2 = az_reg;
        sq_p  = (state_reg == ST_SQ1) ? sq_a1 * sq_a1 : sq_a2 * sq_a2;

        rem_sh    = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1 -: 2]};
        rem_trial = {1'b0, root_reg, 2'b01};

        // cordic start vector for this axis
        unique case (axis_reg)
            2'd0:
            begin
                ix = cvec_t'({{(CV_W-ROOT_W){1'b0}}, root_reg});
                iy = cvec_t'({{(CV_W-IN_W){ay_reg[IN_W-1]}}, ay_reg}) <<< 8;
            end
            2'd1:
            begin
                ix = cvec_t'({{(CV_W-ROOT_W){1'b0}}, root_reg});
                iy = -(cvec_t'({{(CV_W-IN_W){ax_reg[IN_W-1]}}, ax_reg}) <<< 8);
            end
            default:
            begin
                ix = cvec_t'({{(CV_W-Z_W){ang_reg[0][Z_W-1]}}, ang_reg[0]});
                iy = cvec_t'({{(CV_W-Z_W){ang_reg[1][Z_W-1]}}, ang_reg[1]});
            end
        endcase
        xs = cx_reg >>> cnt_reg[TIDX_W-1:0];
        ys = cy_reg >>> cnt_reg[TIDX_W-1:0];

        gmag    = g_reg[axis_reg][IN_W-1] ? (~g_reg[axis_reg] + 1'b1) : g_reg[axis_reg];
        drem_sh = {drem_reg[DREM_W-2:0], prod_reg[PROD_W-1]};

        delta = g_reg[axis_reg][IN_W-1] ? -$signed({2'b00, quo_reg})
                                        : $signed({2'b00, quo_reg});
        bsum  = BA_W'(delta) +
                (BA_W'(fused_reg[axis_reg]) <<< 8);
        wclamp = (blend_reg > WT_ONE) ? WT_ONE : blend_reg;

        nsum = acc_reg + (wa_reg[0] ? ma_reg : '0) + (wb_reg[0] ? mb_reg : '0);

        res     = RES_W'((acc_reg + RND_HALF) >>> 24);
        res_sat = (res > ANG_MAXV) || (res < ANG_MINV);
        if (res > ANG_MAXV)
            res_clamp = ANG_MAXV[ANG_W-1:0];
        else if (res < ANG_MINV)
            res_clamp = ANG_MINV[ANG_W-1:0];
        else
            res_clamp = res[ANG_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            axis_reg      <= 2'd0;
            cnt_reg       <= '0;
            fused_reg[0]  <= '0;
            fused_reg[1]  <= '0;
            fused_reg[2]  <= '0;
            sat_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_acc)
                    begin
                        axis_reg  <= 2'd0;
                        sat_reg   <= 1'b0;
                        state_reg <= ST_SQ1;
                    end
                end
                ST_SQ1:
                begin
                    sq_reg    <= sq_p[SQ_W-1:0];
                    state_reg <= ST_SQ2;
                end
                ST_SQ2:
                begin
                    // magnitude squared, Q.16
                    rad_reg   <= {RAD_W'({1'b0, sq_reg} + {1'b0, sq_p[SQ_W-1:0]})} << 16;
                    root_reg  <= '0;
                    rem_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_SQRT;
                end
                ST_SQRT:
                begin
                    if (rem_sh >= rem_trial)
                    begin
                        rem_reg  <= rem_sh - rem_trial;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg  <= rem_sh;
                        root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
                    end
                    rad_reg <= rad_reg << 2;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(ROOT_W - 1))
                        state_reg <= ST_CINIT;
                end
                ST_CINIT:
                begin
                    zero_reg <= (ix == '0) && (iy == '0);
                    // quadrant pre-rotation for a vector in the left half plane
                    if (ix < 0)
                    begin
                        if (iy >= 0)
                        begin
                            cx_reg <= iy;
                            cy_reg <= -ix;
                            cz_reg <= Z_RIGHT;
                        end
                        else
                        begin
                            cx_reg <= -iy;
                            cy_reg <= ix;
                            cz_reg <= -Z_RIGHT;
                        end
                    end
                    else
                    begin
                        cx_reg <= ix;
                        cy_reg <= iy;
                        cz_reg <= '0;
                    end
                    cnt_reg   <= '0;
                    state_reg <= ST_CORD;
                end
                ST_CORD:
                begin
                    if (cnt_reg == CNT_W'(N_STEPS))
                    begin
                        ang_reg[axis_reg] <= zero_reg ? '0 : cz_reg;
                        state_reg         <= ST_GM0;
                    end
                    else
                    begin
                        if (cy_reg >= 0)
                        begin
                            cx_reg <= cx_reg + ys;
                            cy_reg <= cy_reg - xs;
                            cz_reg <= cz_reg + atan_entry(cnt_reg[TIDX_W-1:0]);
                        end
                        else
                        begin
                            cx_reg <= cx_reg - ys;
                            cy_reg <= cy_reg + xs;
                            cz_reg <= cz_reg - atan_entry(cnt_reg[TIDX_W-1:0]);
                        end
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                ST_GM0:
                begin
                    mcand_reg  <= PROD_W'(MC_W'(gmag) * MC_W'(gain_reg));
                    mplier_reg <= us_reg;
                    prod_reg   <= '0;
                    cnt_reg    <= '0;
                    state_reg  <= ST_GMUL;
                end
                ST_GMUL:
                begin
                    if (mplier_reg[0])
                        prod_reg <= prod_reg + mcand_reg;
                    mcand_reg  <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    cnt_reg    <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(US_W - 1))
                        state_reg <= ST_GRND;
                end
                ST_GRND:
                begin
                    prod_reg  <= prod_reg + GYRO_HALF;
                    drem_reg  <= '0;
                    quo_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_GDIV;
                end
                ST_GDIV:
                begin
                    if (drem_sh >= GYRO_DEN)
                    begin
                        drem_reg <= drem_sh - GYRO_DEN;
                        quo_reg  <= {quo_reg[QUO_W-2:0], 1'b1};
                    end
                    else
                    begin
                        drem_reg <= drem_sh;
                        quo_reg  <= {quo_reg[QUO_W-2:0], 1'b0};
                    end
                    prod_reg <= prod_reg << 1;
                    cnt_reg  <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(PROD_W - 1))
                        state_reg <= ST_BINIT;
                end
                ST_BINIT:
                begin
                    ma_reg    <= BN_W'(bsum);
                    mb_reg    <= BN_W'(ang_reg[axis_reg]);
                    wa_reg    <= wclamp;
                    wb_reg    <= WT_ONE - wclamp;
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_BLEND;
                end
                ST_BLEND:
                begin
                    acc_reg <= nsum;
                    ma_reg  <= ma_reg <<< 1;
                    mb_reg  <= mb_reg <<< 1;
                    wa_reg  <= wa_reg >> 1;
                    wb_reg  <= wb_reg >> 1;
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(WT_W - 1))
                        state_reg <= ST_BFIN;
                end
                ST_BFIN:
                begin
                    fused_reg[axis_reg] <= res_clamp;
                    sat_reg             <= sat_reg | res_sat;
                    if (axis_reg == 2'd2)
                        state_reg <= ST_DONE;
                    else
                    begin
                        axis_reg  <= axis_reg + 1'b1;
                        state_reg <= (axis_reg == 2'd1) ? ST_CINIT : ST_SQ1;
                    end
                end
                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // sample and result payload
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            ax_reg   <= accel_x;
            ay_reg   <= accel_y;
            az_reg   <= accel_z;
            g_reg[0] <= gyro_x;
            g_reg[1] <= gyro_y;
            g_reg[2] <= gyro_z;
            us_reg   <= elapsed_us;
        end
        if (state_reg == ST_DONE && (!out_valid_reg || out_ready))
        begin
            roll_reg    <= fused_reg[0];
            pitch_reg   <= fused_reg[1];
            third_reg   <= fused_reg[2];
            sat_out_reg <= sat_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign roll_angle  = roll_reg;
    assign pitch_angle = pitch_reg;
    assign third_angle = third_reg;
    assign saturated   = sat_out_reg;

    // one sample in work at a time
    a_one_in_work: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second sample taken while one is in work");

    // a flagged result has at least one angle at a rail
    a_sat_rail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated |->
            roll_angle == ANG_MAXV[ANG_W-1:0] || roll_angle == ANG_MINV[ANG_W-1:0] ||
            pitch_angle == ANG_MAXV[ANG_W-1:0] || pitch_angle == ANG_MINV[ANG_W-1:0] ||
            third_angle == ANG_MAXV[ANG_W-1:0] || third_angle == ANG_MINV[ANG_W-1:0])
        else $error("saturation flag without a clamped angle");

    // cordic iteration count never runs past the table
    a_cord_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_CORD |-> cnt_reg <= CNT_W'(N_STEPS))
        else $error("cordic step counter overran");
endmodule
`default_nettype wire

// ===== verif/ctf_checker.sv =====
// watches the sample and angle channels and the register port, predicts and compares
`timescale 1ns / 1ps
`default_nettype none
module ctf_checker #(
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [2:0]           paddr,
    input  wire logic [31:0]          pwdata,
    input  wire logic                 pready,
    input  wire logic                 in_valid,
    input  wire logic                 in_ready,
    input  wire logic signed [15:0]   accel_x,
    input  wire logic signed [15:0]   accel_y,
    input  wire logic signed [15:0]   accel_z,
    input  wire logic signed [15:0]   gyro_x,
    input  wire logic signed [15:0]   gyro_y,
    input  wire logic signed [15:0]   gyro_z,
    input  wire logic [19:0]          elapsed_us,
    input  wire logic                 out_valid,
    input  wire logic                 out_ready,
    input  wire logic signed [19:0]   roll_angle,
    input  wire logic signed [19:0]   pitch_angle,
    input  wire logic signed [19:0]   third_angle,
    input  wire logic                 saturated,
    output int                        errors,
    output int                        pending,
    output int                        checked,
    output int                        sat_seen
);
    import ctf_pkg::*;

    typedef struct {
        angle_t roll;
        angle_t pitch;
        angle_t third;
        logic   sat;
    } fused_angles_t;

    localparam longint ATAN_TAB [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    fused_angles_t angle_fifo [$];
    logic [WT_W-1:0]   weight_q;
    logic [GAIN_W-1:0] gain_q;
    longint            st_roll, st_pitch, st_third;

    function automatic longint int_sqrt(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return longint'(r);
    endfunction

    // vectoring rotation, result in Q.16 degrees
    function automatic longint tilt_atan2(longint y, longint x);
        longint z, t, xs, ys;
        int n;
        z = 0;
        n = (CORDIC_STEPS > 24) ? 24 : CORDIC_STEPS;
        if (x == 0 && y == 0) return 0;
        if (x < 0) begin
            if (y >= 0) begin
                t = x; x = y; y = -t; z = 90 * 65536;
            end else begin
                t = x; x = -y; y = t; z = -90 * 65536;
            end
        end
        for (int i = 0; i < n; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
                x = x + ys; y = y - xs; z = z + ATAN_TAB[i];
            end else begin
                x = x - ys; y = y + xs; z = z - ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    // rate counts times gain times microseconds over 256e6, rounded half away from zero
    function automatic longint gyro_increment(longint g, longint unsigned us);
        longint unsigned mag, p, q;
        mag = (g < 0) ? longint'(-g) : longint'(g);
        p = mag * longint'(gain_q) * us;
        q = (p + 64'd128000000) / 64'd256000000;
        return (g < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint blend_axis(longint st, longint delta, longint acc,
                                          ref logic sat);
        longint w, n, r;
        w = (weight_q > 17'd65536) ? 65536 : longint'(weight_q);
        n = w * (st * 256 + delta) + (65536 - w) * acc;
        r = (n + (64'sd1 <<< 23)) >>> 24;
        if (r > 524287) begin r = 524287; sat = 1'b1; end
        if (r < -524288) begin r = -524288; sat = 1'b1; end
        return r;
    endfunction

    function automatic fused_angles_t predict_angles();
        longint ax, ay, az, a_roll, a_pitch, a_third;
        longint unsigned us;
        logic sat;
        fused_angles_t e;
        ax = accel_x; ay = accel_y; az = accel_z;
        us = elapsed_us;
        sat = 1'b0;
        a_roll  = tilt_atan2(ay * 256, int_sqrt(longint'(ax * ax + az * az) << 16));
        a_pitch = tilt_atan2(-ax * 256, int_sqrt(longint'(ay * ay + az * az) << 16));
        a_third = tilt_atan2(a_pitch, a_roll);
        st_roll  = blend_axis(st_roll, gyro_increment(gyro_x, us), a_roll, sat);
        st_pitch = blend_axis(st_pitch, gyro_increment(gyro_y, us), a_pitch, sat);
        st_third = blend_axis(st_third, gyro_increment(gyro_z, us), a_third, sat);
        e.roll  = angle_t'(st_roll);
        e.pitch = angle_t'(st_pitch);
        e.third = angle_t'(st_third);
        e.sat   = sat;
        return e;
    endfunction

    assign pending = angle_fifo.size();

    always @(posedge clk or negedge rst_n) begin
        fused_angles_t e;
        int bad;
        if (!rst_n) begin
            weight_q <= 17'd64225;
            gain_q   <= 24'd511500;
            st_roll = 0; st_pitch = 0; st_third = 0;
            angle_fifo.delete();
            errors <= 0;
            checked <= 0;
            sat_seen <= 0;
        end else begin
            bad = 0;
            if (psel && penable && pwrite && pready) begin
                if (paddr[2] == REG_BLEND) weight_q <= pwdata[WT_W-1:0];
                else if (paddr[2] == REG_GAIN) gain_q <= pwdata[GAIN_W-1:0];
            end
            // the older result leaves before a new sample is predicted
            if (out_valid && out_ready) begin
                if (angle_fifo.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    bad = bad + 1;
                end else begin
                    e = angle_fifo.pop_front();
                    checked <= checked + 1;
                    if (saturated) sat_seen <= sat_seen + 1;
                    if (roll_angle !== e.roll) begin
                        $error("roll_angle expected %0d actual %0d", e.roll, roll_angle);
                        bad = bad + 1;
                    end
                    if (pitch_angle !== e.pitch) begin
                        $error("pitch_angle expected %0d actual %0d", e.pitch, pitch_angle);
                        bad = bad + 1;
                    end
                    if (third_angle !== e.third) begin
                        $error("third_angle expected %0d actual %0d", e.third, third_angle);
                        bad = bad + 1;
                    end
                    if (saturated !== e.sat) begin
                        $error("saturated expected %0d actual %0d", e.sat, saturated);
                        bad = bad + 1;
                    end
                end
            end
            if (bad != 0)
                errors <= errors + bad;
            if (in_valid && in_ready)
                angle_fifo = {angle_fifo, predict_angles()};
        end
    end
endmodule
`default_nettype wire

// ===== verif/tb.sv =====
// top of the tilt filter testbench: clock, reset, stimulus and verdict
`timescale 1ns / 1ps
`default_nettype none
module tb;
    import ctf_pkg::*;

    localparam longint CYCLE_LIMIT = 6000000;
    localparam int     DRAIN_CYCLES = 600;   // a bit over one item's latency

    logic clk, rst_n;
    logic psel, penable, pwrite, pready;
    logic [2:0] paddr;
    logic [31:0] pwdata, prdata;
    logic in_valid, in_ready, out_valid, out_ready;
    logic signed [15:0] accel_x, accel_y, accel_z, gyro_x, gyro_y, gyro_z;
    logic [19:0] elapsed_us;
    logic signed [19:0] roll_angle, pitch_angle, third_angle;
    logic saturated;
    int errors, pending, checked, sat_seen;
    int burst_left;
    int settings_run;
    longint cycles;

    complementary_tilt_filter dut (.*);

    ctf_checker chk (
        .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .in_valid, .in_ready, .accel_x, .accel_y, .accel_z,
        .gyro_x, .gyro_y, .gyro_z, .elapsed_us,
        .out_valid, .out_ready, .roll_angle, .pitch_angle, .third_angle,
        .saturated, .errors, .pending, .checked, .sat_seen
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // watchdog on total run length
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    // receiver stalls: always ready, random, long stalls or mostly ready, switched now and then
    initial
    begin
        int mode, left;
        out_ready = 1'b0;
        mode = 0;
        left = 0;
        forever
        begin
            @(negedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(200, 3000);
            end
            left--;
            case (mode)
                0: out_ready <= 1'b1;
                1: out_ready <= ($urandom_range(0, 1) == 1);
                2: out_ready <= ($urandom_range(0, 99) < 3);
                default: out_ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    // one register write: setup cycle then access cycle
    task automatic reg_write(input logic sel, input logic [31:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // hold off until every result is back and the sequencer has gone quiet
    task automatic wait_idle();
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic change_setting(input logic [31:0] wt, input logic [31:0] gain);
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        wait_idle();
        reg_write(REG_BLEND, wt);
        reg_write(REG_GAIN, gain);
        settings_run++;
    endtask

    // one sample beat; bursts keep valid high across beats, gaps drop it
    task automatic send_sample(input logic signed [15:0] ax, ay, az, gx, gy, gz,
                               input logic [19:0] us);
        int gap;
        @(negedge clk);
        in_valid   <= 1'b1;
        accel_x    <= ax;
        accel_y    <= ay;
        accel_z    <= az;
        gyro_x     <= gx;
        gyro_y     <= gy;
        gyro_z     <= gz;
        elapsed_us <= us;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        if (burst_left > 0) burst_left--;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 700);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // mostly plausible motion, some full-range noise
    task automatic send_random();
        logic signed [15:0] ax, ay, az, gx, gy, gz;
        logic [19:0] us;
        if ($urandom_range(0, 99) < 80)
        begin
            ax = 16'($urandom_range(0, 36000) - 18000);
            ay = 16'($urandom_range(0, 36000) - 18000);
            az = 16'($urandom_range(0, 36000) - 18000);
            gx = 16'($urandom_range(0, 4000) - 2000);
            gy = 16'($urandom_range(0, 4000) - 2000);
            gz = 16'($urandom_range(0, 4000) - 2000);
            us = 20'($urandom_range(0, 20000));
        end
        else
        begin
            ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
            gx = 16'($urandom); gy = 16'($urandom); gz = 16'($urandom);
            us = 20'($urandom);
        end
        send_sample(ax, ay, az, gx, gy, gz, us);
    endtask

    initial
    begin
        rst_n = 1'b0;
        psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
        in_valid = 1'b0;
        accel_x = '0; accel_y = '0; accel_z = '0;
        gyro_x = '0; gyro_y = '0; gyro_z = '0; elapsed_us = '0;
        burst_left = 0;
        settings_run = 1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed, reset setting
        send_sample(0, 0, 0, 0, 0, 0, 0);                  // zero vectors everywhere
        send_sample(0, 16384, 0, 0, 0, 0, 1000);           // zero denominator, roll
        send_sample(16384, 0, 0, 0, 0, 0, 1000);           // zero denominator, pitch
        send_sample(0, -16384, 0, 0, 0, 0, 1000);
        send_sample(-16384, -16384, 1000, 100, -100, 50, 5000); // negative roll pre-rotation
        send_sample(16384, -8000, 9000, 0, 0, 0, 5000);
        send_sample(-32768, -32768, -32768, -32768, -32768, -32768, 20'hFFFFF);
        send_sample(32767, 32767, 32767, 32767, 32767, 32767, 20'hFFFFF);
        send_sample(32767, -32768, 0, -32768, 32767, -1, 20'hFFFFF);
        send_sample(-1, 1, -1, 1, -1, 1, 1);

        // weight exactly one, largest gain: gyro only, saturates quickly
        change_setting(32'd65536, 32'hFFFFFF);
        send_sample(100, 200, 16000, 32767, -32768, 12345, 20'hFFFFF);
        send_sample(0, 0, 16384, -32768, 32767, -12345, 20'hFFFFF);
        send_sample(0, 0, 16384, 0, 0, 0, 0);

        // weight zero, no gain: pure accelerometer tilt
        change_setting(32'd0, 32'd0);
        send_sample(3000, -4000, 15000, 32767, 32767, 32767, 20'hFFFFF);
        send_sample(-16384, 0, 0, 0, 0, 0, 0);
        send_sample(0, 0, 0, 0, 0, 0, 0);

        // weight above one is treated as one
        change_setting(32'h1FFFF, 32'd511500);
        send_sample(2000, 2000, 16000, 300, -300, 900, 10000);
        send_sample(-2000, 5000, -16000, -300, 300, -900, 10000);

        // random phases across a spread of settings
        change_setting(32'd64225, 32'd511500);
        repeat (500) send_random();
        change_setting($urandom_range(0, 65536), $urandom);
        repeat (300) send_random();
        change_setting(32'd65536, 32'd0);
        repeat (200) send_random();
        change_setting(32'd0, 32'hFFFFFF);
        repeat (200) send_random();
        change_setting($urandom_range(65537, 131071), $urandom_range(0, 2000000));
        repeat (200) send_random();
        change_setting($urandom_range(40000, 65536), $urandom_range(100000, 1000000));
        repeat (500) send_random();

        @(negedge clk);
        in_valid <= 1'b0;
        wait_idle();

        $display("checked %0d result beats under %0d register settings, %0d saturated",
                 checked, settings_run, sat_seen);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end
endmodule
`default_nettype wire

// ===== complementary_tilt_filter.f =====
hdl/ctf_pkg.sv
hdl/complementary_tilt_filter.sv
verif/ctf_checker.sv
verif/tb.sv
